/* design/mncg_pkg.sv */
// Shared types and constants of the MIDI note-on channel gate.
`default_nettype none

package mncg_pkg;

  // Input item kinds
  localparam logic [1:0] FUNC_RAW   = 2'd0;
  localparam logic [1:0] FUNC_PAD   = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  // Status nibbles and message bytes
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [7:0] CC_ALL_OFF   = 8'd123;
  localparam logic [7:0] LEN_THREE    = 8'd3;
  localparam logic [7:0] LEN_TWO      = 8'd2;
  localparam logic [7:0] DATA_MASK    = 8'h7F;
  localparam logic [3:0] FLUSH_LAST_CH = 4'hF;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [15:0] MASK_RESET  = 16'hFFFF;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_UP   = 2'd1,
    CNT_DOWN = 2'd2
  } cnt_op_t;

  // One classified item between the front and back parts
  typedef struct packed {
    logic        flush;
    cnt_op_t     op;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [7:0]  length;
    logic [15:0] offset;
  } entry_t;

endpackage

`default_nettype wire

/* design/mncg_front.sv */
// Front part: channel mask register and item classification.
`default_nettype none

module mncg_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  input  wire logic [15:0]     cfg_data,
  input  wire logic            accept,
  input  wire logic [1:0]      func,
  input  wire logic [7:0]      raw_status,
  input  wire logic [7:0]      raw_data1,
  input  wire logic [7:0]      raw_data2,
  input  wire logic [7:0]      raw_length,
  input  wire logic [15:0]     sample_offset,
  input  wire logic            pad_note_on,
  input  wire logic [4:0]      pad_channel,
  output logic                 wr_en,
  output mncg_pkg::entry_t     wr_data
);

  logic [15:0] channel_mask;
  logic        drop;
  logic        len_three;
  logic        raw_on;
  logic        raw_off;
  logic [4:0]  pad_idx;
  logic        pad_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask <= mncg_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      channel_mask <= cfg_data;
    end
  end

  always_comb begin
    len_three    = raw_length >= mncg_pkg::LEN_THREE;
    raw_on       = len_three && raw_status[7:4] == mncg_pkg::NIB_NOTE_ON && raw_data2 != 8'd0;
    raw_off      = len_three && (raw_status[7:4] == mncg_pkg::NIB_NOTE_OFF ||
                   (raw_status[7:4] == mncg_pkg::NIB_NOTE_ON && raw_data2 == 8'd0));
    pad_idx      = pad_channel - 5'd1;
    pad_in_range = pad_channel != 5'd0 && pad_channel <= 5'd16;

    drop            = 1'b0;
    wr_data.flush   = 1'b0;
    wr_data.op      = mncg_pkg::CNT_NONE;
    wr_data.status  = raw_status;
    wr_data.data1   = (raw_length >= mncg_pkg::LEN_TWO) ? raw_data1 : 8'd0;
    wr_data.data2   = len_three ? raw_data2 : 8'd0;
    wr_data.length  = raw_length;
    wr_data.offset  = sample_offset;

    unique case (func)
      mncg_pkg::FUNC_RAW: begin
        drop = raw_on && !channel_mask[raw_status[3:0]];
        if (raw_on) begin
          wr_data.op = mncg_pkg::CNT_UP;
        end else if (raw_off) begin
          wr_data.op = mncg_pkg::CNT_DOWN;
        end
      end
      mncg_pkg::FUNC_PAD: begin
        drop           = pad_note_on && pad_in_range && !channel_mask[pad_idx[3:0]];
        wr_data.op     = pad_note_on ? mncg_pkg::CNT_UP : mncg_pkg::CNT_DOWN;
        wr_data.status = {pad_note_on ? mncg_pkg::NIB_NOTE_ON : mncg_pkg::NIB_NOTE_OFF,
                          pad_idx[3:0]};
        wr_data.data1  = raw_data1 & mncg_pkg::DATA_MASK;
        wr_data.data2  = raw_data2 & mncg_pkg::DATA_MASK;
        wr_data.length = mncg_pkg::LEN_THREE;
        wr_data.offset = 16'd0;
      end
      mncg_pkg::FUNC_FLUSH: begin
        wr_data.flush = 1'b1;
      end
      mncg_pkg::FUNC_NONE: begin
        drop = 1'b1;
      end
      default: begin
        drop = 1'b1;
      end
    endcase

    wr_en = accept && !drop;
  end

endmodule

`default_nettype wire

/* design/mncg_queue.sv */
// Short register queue of classified items between front and back.
`default_nettype none

module mncg_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire mncg_pkg::entry_t wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output mncg_pkg::entry_t      rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  mncg_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_FULL;
  assign rd_valid = count != '0;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/mncg_back.sv */
// Back part: voice counter, flush expansion and result register.
`default_nettype none

module mncg_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire mncg_pkg::entry_t head,
  output logic                  deq,
  input  wire logic             pop,
  output logic                  empty,
  output logic [7:0]            out_status,
  output logic [7:0]            out_data1,
  output logic [7:0]            out_data2,
  output logic [7:0]            out_length,
  output logic [15:0]           out_offset,
  output logic [15:0]           voice_count,
  output logic                  last
);

  logic        out_valid;
  logic [3:0]  flush_ch;
  logic [15:0] live_voices;
  logic [15:0] live_voices_next;
  logic        load;
  logic [7:0]  beat_status;
  logic [7:0]  beat_data1;
  logic [7:0]  beat_data2;
  logic [7:0]  beat_length;
  logic [15:0] beat_offset;
  logic        beat_last;

  assign empty = !out_valid;
  assign load  = head_valid && (!out_valid || pop);
  assign deq   = load && (!head.flush || flush_ch == mncg_pkg::FLUSH_LAST_CH);

  always_comb begin
    if (head.flush) begin
      beat_status      = {mncg_pkg::NIB_CTRL, flush_ch};
      beat_data1       = mncg_pkg::CC_ALL_OFF;
      beat_data2       = 8'd0;
      beat_length      = mncg_pkg::LEN_THREE;
      beat_offset      = 16'd0;
      beat_last        = flush_ch == mncg_pkg::FLUSH_LAST_CH;
      live_voices_next = 16'd0;
    end else begin
      beat_status = head.status;
      beat_data1  = head.data1;
      beat_data2  = head.data2;
      beat_length = head.length;
      beat_offset = head.offset;
      beat_last   = 1'b1;
      case (head.op)
        mncg_pkg::CNT_UP: begin
          live_voices_next = (live_voices == mncg_pkg::COUNT_MAX) ? live_voices
                                                                  : live_voices + 16'd1;
        end
        mncg_pkg::CNT_DOWN: begin
          live_voices_next = (live_voices == 16'd0) ? live_voices : live_voices - 16'd1;
        end
        default: begin
          live_voices_next = live_voices;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      flush_ch    <= '0;
      live_voices <= '0;
    end else begin
      if (load) begin
        out_valid   <= 1'b1;
        live_voices <= live_voices_next;
        if (head.flush) begin
          flush_ch <= flush_ch + 4'd1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status  <= beat_status;
      out_data1   <= beat_data1;
      out_data2   <= beat_data2;
      out_length  <= beat_length;
      out_offset  <= beat_offset;
      voice_count <= live_voices_next;
      last        <= beat_last;
    end
  end

endmodule

`default_nettype wire

/* design/midi_note_on_channel_gate_unit.sv */
// Top level of the MIDI note-on channel gate with live-voice counter.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------------
//   input     push / full          func, raw_*, sample_offset, pad_note_on, pad_channel
//   result    pop / empty          out_status, out_data1/2, out_length, out_offset,
//                                  voice_count, last
//   config    cfg_valid/cfg_ready  cfg_data (channel mask, bit c-1 gates channel c)
//
// One input beat is taken per cycle while the item queue has room; a result is
// registered on the result ports once its item reaches the queue head and the
// result register is empty or popped. A flush expands into sixteen result beats,
// one per cycle while results are popped. Masked note-ons and unused func codes
// are dropped at the front. Reset (rst, synchronous) empties the queue, clears
// the voice count and opens all channels. cfg_ready is always high.
`default_nettype none

module midi_note_on_channel_gate_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // input items
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  raw_status,
  input  wire logic [7:0]  raw_data1,
  input  wire logic [7:0]  raw_data2,
  input  wire logic [7:0]  raw_length,
  input  wire logic [15:0] sample_offset,
  input  wire logic        pad_note_on,
  input  wire logic [4:0]  pad_channel,
  // result items
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_status,
  output logic [7:0]       out_data1,
  output logic [7:0]       out_data2,
  output logic [7:0]       out_length,
  output logic [15:0]      out_offset,
  output logic [15:0]      voice_count,
  output logic             last
);

  logic             wr_en;
  mncg_pkg::entry_t wr_data;
  logic             head_valid;
  mncg_pkg::entry_t head;
  logic             deq;
  logic             accept;

  // Mask writes are registered and never stalled; no backpressure on the config channel.
  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Classify the beat and drop what never produces a result.
  mncg_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .func          (func),
    .raw_status    (raw_status),
    .raw_data1     (raw_data1),
    .raw_data2     (raw_data2),
    .raw_length    (raw_length),
    .sample_offset (sample_offset),
    .pad_note_on   (pad_note_on),
    .pad_channel   (pad_channel),
    .wr_en         (wr_en),
    .wr_data       (wr_data)
  );

  // Hold up to QUEUE_DEPTH classified items so the front can run ahead of a
  // long flush; the input stalls only once the queue is full.
  mncg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .full     (full),
    .rd_en    (deq),
    .rd_valid (head_valid),
    .rd_data  (head)
  );

  // Advance the voice count and register each result beat.
  mncg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .deq         (deq),
    .pop         (pop),
    .empty       (empty),
    .out_status  (out_status),
    .out_data1   (out_data1),
    .out_data2   (out_data2),
    .out_length  (out_length),
    .out_offset  (out_offset),
    .voice_count (voice_count),
    .last        (last)
  );

endmodule

`default_nettype wire
